>>> src/s2l_pkg.sv
// Package for the solar to lunar date converter: lunar year table and Gregorian month offsets.
package s2l_pkg;

    localparam int unsigned YEAR_BASE = 1901;
    localparam int unsigned ROM_DEPTH = 256;

    localparam logic [23:0] LUNAR_ROM [0:ROM_DEPTH-1] = '{
        24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544,
        24'h46AAB9, 24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A,
        24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA, 24'h0B544E,
        24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754,
        24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8,
        24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
        24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
        24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48,
        24'h6DA53B, 24'h0B554F, 24'h056A45, 24'h4AADB9, 24'h025D4D,
        24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD, 24'h06CA51,
        24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8,
        24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h6AD53C,
        24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642,
        24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
        24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B,
        24'h8D52BF, 24'h0B5452, 24'h0B6A47, 24'h696D3C, 24'h095B50,
        24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2, 24'h06A554,
        24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
        24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF,
        24'h05AC53, 24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645,
        24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
        24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
        24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53,
        24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
        24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D,
        24'h0A4E51, 24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
        24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48,
        24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
        24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51,
        24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
        24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C,
        24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
        24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545,
        24'h55AABA, 24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
        24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
        24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
        24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA,
        24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E,
        24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45,
        24'h4A4EB9, 24'h0A4D4C, 24'h0D1541, 24'h2D92B5,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0
    };

    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

>>> src/solar_to_lunar_date.sv
// Gregorian to Chinese lunar date converter, top level.
//
// Usage: present solar_year/solar_month/solar_day with in_valid; a transfer
// happens on a clock edge with in_valid high and in_stall low. One item is
// converted at a time; in_stall is high from the transfer until the block
// is idle again. Each item produces exactly one result on the out channel
// (out_valid/out_stall), with valid_res low and all fields zero when the
// year or month is out of range.
// Sequence: after the input transfer the block reads this year's table word,
// then the previous year's, runs setup, walks the year word one month slot per
// cycle over at most 12 lunar months until the day falls inside the month, and
// loads the output register; an out-of-range item goes from the first read
// straight to the output load. The block returns to idle as its result is
// loaded and can then take the next item. The two table reads (this year and
// the previous year) share the single ROM read port.
// The result sits in an output register: a new item is taken while a
// finished result waits, and the walk holds its result until the output
// register frees up when the receiver stalls.
// Reset clears the sequencer and out_valid; no item is in flight after it.
module solar_to_lunar_date #(
    parameter int unsigned YEAR_COUNT = 199
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] solar_year,
    input  logic [3:0]  solar_month,
    input  logic [4:0]  solar_day,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] lunar_year,
    output logic [3:0]  lunar_month,
    output logic [4:0]  lunar_day,
    output logic        leap_month_flag,
    output logic        valid_res
);

    localparam logic [11:0] YEAR_MIN = 12'd1902;
    localparam logic [11:0] YEAR_MAX = 12'(1900 + YEAR_COUNT);
    localparam logic [11:0] YEAR_LEAP_SKIP = 12'd2100;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RDCUR = 6'b000010,
        S_RDPRV = 6'b000100,
        S_SETUP = 6'b001000,
        S_WALK  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic        inrange_reg;

    logic [7:0]  rom_addr;
    logic [23:0] rom_data_reg;
    logic [23:0] cur_word_reg;

    logic [23:0] word_reg;
    logic [3:0]  lm_reg;
    logic [8:0]  rem_reg;
    logic [3:0]  mon_reg;
    logic [3:0]  slot_reg;
    logic [3:0]  last_reg;
    logic        passed_reg;
    logic        back_reg;
    logic [11:0] lyear_reg;

    logic [11:0] res_year_reg;
    logic [3:0]  res_month_reg;
    logic [4:0]  res_day_reg;
    logic        res_leap_reg;
    logic        res_valid_reg;

    logic        out_valid_reg;
    logic [11:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic        out_leap_reg;
    logic        out_res_reg;

    logic               in_xfer;
    logic               out_free;
    logic               leap_year;
    logic signed [10:0] spring;
    logic signed [10:0] doy;
    logic signed [10:0] diff;
    logic               backward;
    logic [3:0]         lm_prev;
    logic [3:0]         lm_cur;
    logic [4:0]         len;
    logic               step;
    logic signed [10:0] day_raw;
    logic [4:0]         day_sat;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // ROM: one read port, registered data
    assign rom_addr = (state_reg == S_RDCUR) ? 8'(year_reg - 12'(s2l_pkg::YEAR_BASE))
                                              : 8'(year_reg - 12'(s2l_pkg::YEAR_BASE + 1));

    always_ff @(posedge clk)
    begin
        rom_data_reg <= s2l_pkg::LUNAR_ROM[rom_addr];
    end

    // setup arithmetic, valid only in S_SETUP (rom_data_reg holds previous year)
    assign leap_year = (year_reg[1:0] == 2'd0) && (year_reg != YEAR_LEAP_SKIP);
    assign spring = (cur_word_reg[6:5] == 2'd1) ? $signed({6'd0, cur_word_reg[4:0]}) - 11'sd1
                                                 : $signed({6'd0, cur_word_reg[4:0]}) + 11'sd30;
    assign doy = $signed({2'd0, s2l_pkg::days_before(month_reg)}) + $signed({6'd0, day_reg})
                 - 11'sd1 + ((leap_year && month_reg > 4'd2) ? 11'sd1 : 11'sd0);
    assign backward = (doy < spring);
    assign diff = backward ? (spring - doy) : (doy - spring);
    assign lm_prev = rom_data_reg[23:20];
    assign lm_cur = cur_word_reg[23:20];

    // one month slot per cycle
    assign len = word_reg[5'd20 - {1'b0, slot_reg}] ? 5'd30 : 5'd29;
    assign step = back_reg ? ((rem_reg > {4'd0, len}) && (slot_reg > 4'd1))
                           : ((rem_reg >= {4'd0, len}) && (slot_reg < last_reg));
    assign day_raw = back_reg ? ($signed({6'd0, len}) - $signed({2'd0, rem_reg}) + 11'sd1)
                              : ($signed({2'd0, rem_reg}) + 11'sd1);
    assign day_sat = (day_raw < 11'sd1) ? 5'd1 :
                     (day_raw > 11'sd30) ? 5'd30 : 5'(day_raw);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_xfer) state_next = S_RDCUR;
            S_RDCUR: state_next = inrange_reg ? S_RDPRV : S_DONE;
            S_RDPRV: state_next = S_SETUP;
            S_SETUP: state_next = S_WALK;
            S_WALK:  if (!step) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            year_reg    <= solar_year;
            month_reg   <= solar_month;
            day_reg     <= solar_day;
            inrange_reg <= (solar_year >= YEAR_MIN) && (solar_year <= YEAR_MAX)
                           && (solar_month >= 4'd1) && (solar_month <= 4'd12);
        end

        if (state_reg == S_RDCUR && !inrange_reg)
        begin
            res_year_reg  <= 12'd0;
            res_month_reg <= 4'd0;
            res_day_reg   <= 5'd0;
            res_leap_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end

        if (state_reg == S_RDPRV)
            cur_word_reg <= rom_data_reg;

        if (state_reg == S_SETUP)
        begin
            back_reg <= backward;
            rem_reg  <= 9'(diff);
            if (backward)
            begin
                word_reg   <= rom_data_reg;
                lm_reg     <= lm_prev;
                lyear_reg  <= year_reg - 12'd1;
                mon_reg    <= 4'd12;
                passed_reg <= (lm_prev == 4'd0);
                slot_reg   <= (lm_prev == 4'd0) ? 4'd12 : 4'd13;
                last_reg   <= 4'd13;
            end
            else
            begin
                word_reg   <= cur_word_reg;
                lm_reg     <= lm_cur;
                lyear_reg  <= year_reg;
                mon_reg    <= 4'd1;
                passed_reg <= 1'b0;
                slot_reg   <= 4'd1;
                last_reg   <= (lm_cur == 4'd0) ? 4'd12 : 4'd13;
            end
        end

        if (state_reg == S_WALK)
        begin
            if (step)
            begin
                if (lm_reg == mon_reg && !passed_reg)
                    passed_reg <= 1'b1;
                else
                    mon_reg <= back_reg ? (mon_reg - 4'd1) : (mon_reg + 4'd1);
                slot_reg <= back_reg ? (slot_reg - 4'd1) : (slot_reg + 4'd1);
                rem_reg  <= rem_reg - {4'd0, len};
            end
            else
            begin
                res_year_reg  <= lyear_reg;
                res_month_reg <= mon_reg;
                res_day_reg   <= day_sat;
                res_leap_reg  <= back_reg ? ((lm_reg == mon_reg) && !passed_reg)
                                          : ((lm_reg != 4'd0) && (lm_reg == mon_reg)
                                             && passed_reg);
                res_valid_reg <= 1'b1;
            end
        end

        if (state_reg == S_DONE && out_free)
        begin
            out_year_reg  <= res_year_reg;
            out_month_reg <= res_month_reg;
            out_day_reg   <= res_day_reg;
            out_leap_reg  <= res_leap_reg;
            out_res_reg   <= res_valid_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign lunar_year      = out_year_reg;
    assign lunar_month     = out_month_reg;
    assign lunar_day       = out_day_reg;
    assign leap_month_flag = out_leap_reg;
    assign valid_res       = out_res_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_RDCUR))
        else $error("accepted transfer did not start a conversion");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (lunar_year == 12'd0 && lunar_month == 4'd0
                                       && lunar_day == 5'd0 && !leap_month_flag))
        else $error("out of range result carries nonzero fields");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> (lunar_day >= 5'd1 && lunar_day <= 5'd30))
        else $error("lunar day outside 1..30");

endmodule

>>> tb/sv/tb_solar_to_lunar_date.sv
// Testbench for solar_to_lunar_date: random and directed dates checked against a lunar calendar predictor.
module tb_solar_to_lunar_date;

    localparam int YEAR_COUNT  = 199;
    localparam int FIRST_YEAR  = 1901;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_COUNT  = 1550;
    localparam int CALM_TAIL   = 200;

    localparam bit [23:0] YEAR_WORDS [0:YEAR_COUNT-1] = '{
        24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544,
        24'h46AAB9, 24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A,
        24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA, 24'h0B544E,
        24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754,
        24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8,
        24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
        24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
        24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48,
        24'h6DA53B, 24'h0B554F, 24'h056A45, 24'h4AADB9, 24'h025D4D,
        24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD, 24'h06CA51,
        24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8,
        24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h6AD53C,
        24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642,
        24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
        24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B,
        24'h8D52BF, 24'h0B5452, 24'h0B6A47, 24'h696D3C, 24'h095B50,
        24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2, 24'h06A554,
        24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
        24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF,
        24'h05AC53, 24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645,
        24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
        24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
        24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53,
        24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
        24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D,
        24'h0A4E51, 24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
        24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48,
        24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
        24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51,
        24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
        24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C,
        24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
        24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545,
        24'h55AABA, 24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
        24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
        24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
        24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA,
        24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E,
        24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45,
        24'h4A4EB9, 24'h0A4D4C, 24'h0D1541, 24'h2D92B5
    };

    localparam int MONTH_START [0:11] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct packed {
        bit [11:0] year;
        bit [3:0]  month;
        bit [4:0]  day;
        bit        leap;
        bit        ok;
    } lunar_t;

    class lunar_scoreboard;
        lunar_t pending_dates[$];
        int     errors;
        int     checked;
        int     in_range;
        int     leap_hits;

        function new();
            errors    = 0;
            checked   = 0;
            in_range  = 0;
            leap_hits = 0;
        endfunction

        static function int month_len(bit [23:0] word, int slot);
            return word[20-slot] ? 30 : 29;
        endfunction

        static function lunar_t to_lunar(bit [11:0] y, bit [3:0] m, bit [4:0] d);
            lunar_t    r;
            bit [23:0] cur;
            bit [23:0] prev;
            int        yi;
            int        lm;
            int        spring;
            int        doy;
            int        rem;
            int        mon;
            int        slot;
            int        len;
            int        last;
            int        dd;
            bit        passed;
            bit        leap;
            r  = '0;
            yi = int'(y);
            if (yi < FIRST_YEAR + 1 || yi > FIRST_YEAR - 1 + YEAR_COUNT || m < 1 || m > 12)
                return r;
            cur  = YEAR_WORDS[yi - FIRST_YEAR];
            prev = YEAR_WORDS[yi - FIRST_YEAR - 1];
            spring = (cur[6:5] == 2'd1) ? int'(cur[4:0]) - 1 : int'(cur[4:0]) + 30;
            doy = MONTH_START[m - 1] + int'(d) - 1;
            if ((((yi % 4) == 0 && (yi % 100) != 0) || (yi % 400) == 0) && m > 2)
                doy++;
            if (doy < spring)
            begin
                // before the festival: walk back through last year's months
                lm     = int'(prev[23:20]);
                rem    = spring - doy;
                r.year = 12'(yi - 1);
                mon    = 12;
                passed = (lm == 0);
                slot   = passed ? 12 : 13;
                forever
                begin
                    len = month_len(prev, slot);
                    if (rem > len && slot > 1)
                    begin
                        if (lm == mon && !passed)
                            passed = 1'b1;
                        else
                            mon--;
                        slot--;
                        rem -= len;
                    end
                    else
                    begin
                        dd   = len - rem + 1;
                        leap = (lm == mon && !passed);
                        break;
                    end
                end
            end
            else
            begin
                lm     = int'(cur[23:20]);
                last   = (lm == 0) ? 12 : 13;
                rem    = doy - spring;
                r.year = 12'(yi);
                mon    = 1;
                slot   = 1;
                passed = 1'b0;
                forever
                begin
                    len = month_len(cur, slot);
                    if (rem >= len && slot < last)
                    begin
                        if (lm == mon && !passed)
                            passed = 1'b1;
                        else
                            mon++;
                        slot++;
                        rem -= len;
                    end
                    else
                    begin
                        dd   = rem + 1;
                        leap = (lm != 0 && lm == mon && passed);
                        break;
                    end
                end
            end
            if (dd < 1)
                dd = 1;
            if (dd > 30)
                dd = 30;
            r.month = 4'(mon);
            r.day   = 5'(dd);
            r.leap  = leap;
            r.ok    = 1'b1;
            return r;
        endfunction

        function void note(bit [11:0] y, bit [3:0] m, bit [4:0] d);
            pending_dates.push_back(to_lunar(y, m, d));
        endfunction

        function void field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check(lunar_t got);
            lunar_t want;
            if (pending_dates.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d leap %0d ok %0d",
                         $time, got.year, got.month, got.day, got.leap, got.ok);
                errors++;
                return;
            end
            want = pending_dates.pop_front();
            checked++;
            if (got.ok)
                in_range++;
            if (got.leap)
                leap_hits++;
            field("lunar_year", int'(want.year), int'(got.year));
            field("lunar_month", int'(want.month), int'(got.month));
            field("lunar_day", int'(want.day), int'(got.day));
            field("leap_month_flag", int'(want.leap), int'(got.leap));
            field("valid_res", int'(want.ok), int'(got.ok));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [11:0] solar_year;
    logic [3:0]  solar_month;
    logic [4:0]  solar_day;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] lunar_year;
    logic [3:0]  lunar_month;
    logic [4:0]  lunar_day;
    logic        leap_month_flag;
    logic        valid_res;

    lunar_scoreboard board = new();

    bit calm_in;
    bit calm_out;
    int stall_left;
    int quiet_cycles;

    solar_to_lunar_date #(
        .YEAR_COUNT(YEAR_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .solar_year(solar_year),
        .solar_month(solar_month),
        .solar_day(solar_day),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .lunar_year(lunar_year),
        .lunar_month(lunar_month),
        .lunar_day(lunar_day),
        .leap_month_flag(leap_month_flag),
        .valid_res(valid_res)
    );

    always #5 clk = ~clk;

    // receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!calm_out && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 14);
        out_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin : result_monitor
        lunar_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.year  = lunar_year;
            got.month = lunar_month;
            got.day   = lunar_day;
            got.leap  = leap_month_flag;
            got.ok    = valid_res;
            board.check(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task send_date(input bit [11:0] y, input bit [3:0] m, input bit [4:0] d);
        if (!calm_in && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        solar_year  <= y;
        solar_month <= m;
        solar_day   <= d;
        do
            @(posedge clk);
        while (in_stall);
        board.note(y, m, d);
        @(negedge clk);
    endtask

    task send_random_date();
        bit [11:0] y;
        bit [3:0]  m;
        bit [4:0]  d;
        int        kind;
        kind = $urandom_range(0, 19);
        y    = 12'($urandom_range(FIRST_YEAR + 1, FIRST_YEAR - 1 + YEAR_COUNT));
        m    = 4'($urandom_range(1, 12));
        d    = 5'($urandom_range(1, 31));
        if (kind < 2)
        begin
            y = 12'($urandom_range(0, 4095));
            m = 4'($urandom_range(0, 15));
            d = 5'($urandom_range(0, 31));
        end
        else if (kind == 2)
        begin
            y = 12'($urandom_range(FIRST_YEAR - 6, FIRST_YEAR + YEAR_COUNT + 10));
            m = 4'($urandom_range(0, 15));
        end
        else if (kind < 7)
            m = 4'($urandom_range(1, 2));
        else if (kind == 7)
            d = $urandom_range(0, 1) ? 5'd0 : 5'd31;
        send_date(y, m, d);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        solar_year  = '0;
        solar_month = '0;
        solar_day   = '0;
        out_stall   = 1'b0;
        stall_left  = 0;
        quiet_cycles = 0;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // range limits and rejects
        send_date(12'd0, 4'd1, 5'd1);
        send_date(12'd4095, 4'd15, 5'd31);
        send_date(12'd1901, 4'd6, 5'd15);
        send_date(12'd1902, 4'd1, 5'd1);
        send_date(12'd2099, 4'd12, 5'd31);
        send_date(12'd2100, 4'd1, 5'd1);
        send_date(12'd1950, 4'd0, 5'd10);
        send_date(12'd1950, 4'd13, 5'd10);
        // festival day and the day before it
        send_date(12'd1902, 4'd2, 5'd7);
        send_date(12'd1902, 4'd2, 5'd8);
        send_date(12'd2099, 4'd1, 5'd20);
        send_date(12'd2099, 4'd1, 5'd21);
        // day zero and days past month end
        send_date(12'd1990, 4'd1, 5'd0);
        send_date(12'd1990, 4'd2, 5'd31);
        send_date(12'd1990, 4'd4, 5'd31);
        // leap-year rule
        send_date(12'd2000, 4'd2, 5'd29);
        send_date(12'd2000, 4'd3, 5'd1);
        send_date(12'd2000, 4'd12, 5'd31);
        send_date(12'd1904, 4'd3, 5'd1);
        // intercalary months, forward and backward walk
        send_date(12'd1903, 4'd7, 5'd10);
        send_date(12'd1984, 4'd12, 5'd15);
        send_date(12'd2033, 4'd12, 5'd25);
        send_date(12'd2034, 4'd1, 5'd5);
        send_date(12'd2096, 4'd12, 5'd31);

        for (int i = 0; i < ITEM_COUNT; i++)
        begin
            if (i % 64 == 0)
            begin
                calm_in  = ($urandom_range(0, 3) == 0);
                calm_out = ($urandom_range(0, 3) == 0);
            end
            if (i >= ITEM_COUNT - CALM_TAIL)
            begin
                calm_in  = 1'b1;
                calm_out = 1'b1;
            end
            send_random_date();
        end
        in_valid <= 1'b0;

        while (board.pending_dates.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Checked %0d conversions: %0d in range, %0d in a leap month, %0d rejected.",
                 board.checked, board.in_range, board.leap_hits,
                 board.checked - board.in_range);
        $display("Mismatches: %0d", board.errors);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
src/s2l_pkg.sv
src/solar_to_lunar_date.sv
tb/sv/tb_solar_to_lunar_date.sv
